/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check an implication in the following cycle, outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fpr_pkg.sv */
`default_nettype none

package fpr_pkg;

    localparam int unsigned MaxPayload = 64;
    localparam int unsigned BufAddrW   = $clog2(MaxPayload);

    localparam logic [7:0] AnyAddress     = 8'hFF;
    localparam logic [7:0] StartMarkerRst = 8'hAA;
    localparam logic [7:0] EndMarkerRst   = 8'h4D;
    localparam logic [7:0] AcceptAddrRst  = 8'hFF;
    localparam logic [6:0] LengthLimitRst = 7'(MaxPayload);

    typedef enum logic [1:0] {
        REG_START_MARKER,
        REG_END_MARKER,
        REG_ACCEPT_ADDRESS,
        REG_LENGTH_LIMIT
    } t_reg_idx;

    typedef struct packed {
        logic                wr_en;
        logic [BufAddrW-1:0] wr_addr;
        logic [7:0]          wr_data;
        logic                rd_en;
        logic [BufAddrW-1:0] rd_addr;
    } t_buf_req;

endpackage

`default_nettype wire

/* design/fpr_payload_buf.sv */
`default_nettype none

module fpr_payload_buf (
    input  wire logic              i_clk,
    input  wire fpr_pkg::t_buf_req i_req,
    output logic [7:0]             o_rd_data
);

    logic [7:0] r_mem [fpr_pkg::MaxPayload];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/framed_packet_receiver.sv */
// Once a frame's end byte is accepted, its first payload byte is read from the buffer and
// then registered at the output. Throughput: one received byte per cycle while receiving
// a frame; an accepted frame's payload then drains one read at a time (buffer read, then
// output register), and no byte is taken until the last payload read has been issued.
// Reset: synchronous, active low; clears the deframer state and loads register defaults.
// The payload buffer is not cleared; every entry is written before it is read.
`default_nettype none
`include "assert_macros.svh"

module framed_packet_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // receive stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // payload stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_address,
                                             // [22:16] frame_length, [23] zero
    output logic             m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ADDR,
        ST_LEN,
        ST_DATA,
        ST_SUM,
        ST_END,
        ST_EMIT
    } t_state;

    t_state     r_state;
    logic [6:0] r_wpos;
    logic [6:0] r_len;
    logic [7:0] r_sum;
    logic [7:0] r_addr;

    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic [7:0] r_accept_addr;
    logic [6:0] r_length_limit;

    logic [6:0] r_rd_cnt;
    logic       r_rd_pend;
    logic       r_rd_last;

    logic       r_out_valid;
    logic       r_out_last;
    logic [7:0] r_out_byte;
    logic [7:0] r_out_addr;
    logic [6:0] r_out_len;

    logic              in_fire;
    logic              pop;
    logic              rd_issue;
    logic              cfg_wr;
    logic [6:0]        n_limit;
    logic              len_bad;
    logic              addr_ok;
    logic [6:0]        n_wpos;
    logic [6:0]        n_rd_cnt;
    logic [7:0]        n_sum;
    logic [7:0]        buf_rdata;
    fpr_pkg::t_buf_req buf_req;
    fpr_pkg::t_reg_idx reg_idx;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state != ST_EMIT);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign pop           = r_out_valid & m_axis_tready;
    assign rd_issue      = (r_state == ST_EMIT) && !r_rd_pend && (!r_out_valid || pop);
    assign cfg_wr        = psel & penable & pwrite & pready;
    assign reg_idx       = fpr_pkg::t_reg_idx'(paddr[3:2]);

    assign n_limit  = (r_length_limit > 7'(fpr_pkg::MaxPayload))
                    ? 7'(fpr_pkg::MaxPayload) : r_length_limit;
    assign len_bad  = (s_axis_tdata == 8'd0) || (s_axis_tdata > {1'b0, n_limit});
    assign addr_ok  = (r_accept_addr == fpr_pkg::AnyAddress) || (r_accept_addr == r_addr);
    assign n_wpos   = r_wpos + 7'd1;
    assign n_rd_cnt = r_rd_cnt + 7'd1;
    assign n_sum    = r_sum + s_axis_tdata;

    always_comb begin
        buf_req.wr_en   = in_fire && (r_state == ST_DATA);
        buf_req.wr_addr = r_wpos[fpr_pkg::BufAddrW-1:0];
        buf_req.wr_data = s_axis_tdata;
        buf_req.rd_en   = rd_issue;
        buf_req.rd_addr = r_rd_cnt[fpr_pkg::BufAddrW-1:0];
    end

    fpr_payload_buf u_buf (
        .i_clk     (i_clk),
        .i_req     (buf_req),
        .o_rd_data (buf_rdata)
    );

    always_comb begin
        case (reg_idx)
            fpr_pkg::REG_START_MARKER:   prdata = {24'd0, r_start_marker};
            fpr_pkg::REG_END_MARKER:     prdata = {24'd0, r_end_marker};
            fpr_pkg::REG_ACCEPT_ADDRESS: prdata = {24'd0, r_accept_addr};
            fpr_pkg::REG_LENGTH_LIMIT:   prdata = {25'd0, r_length_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_HUNT;
            r_wpos         <= 7'd0;
            r_len          <= 7'd0;
            r_sum          <= 8'd0;
            r_addr         <= 8'd0;
            r_start_marker <= fpr_pkg::StartMarkerRst;
            r_end_marker   <= fpr_pkg::EndMarkerRst;
            r_accept_addr  <= fpr_pkg::AcceptAddrRst;
            r_length_limit <= fpr_pkg::LengthLimitRst;
            r_rd_cnt       <= 7'd0;
            r_rd_pend      <= 1'b0;
            r_rd_last      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (reg_idx)
                    fpr_pkg::REG_START_MARKER:   r_start_marker <= pwdata[7:0];
                    fpr_pkg::REG_END_MARKER:     r_end_marker   <= pwdata[7:0];
                    fpr_pkg::REG_ACCEPT_ADDRESS: r_accept_addr  <= pwdata[7:0];
                    fpr_pkg::REG_LENGTH_LIMIT:   r_length_limit <= pwdata[6:0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                case (r_state)
                    ST_HUNT: begin
                        if (s_axis_tdata == r_start_marker) begin
                            r_wpos  <= 7'd0;
                            r_sum   <= 8'd0;
                            r_state <= ST_ADDR;
                        end
                    end
                    ST_ADDR: begin
                        r_sum   <= n_sum;
                        r_addr  <= s_axis_tdata;
                        r_state <= (s_axis_tdata == fpr_pkg::AnyAddress) ? ST_HUNT : ST_LEN;
                    end
                    ST_LEN: begin
                        r_sum <= n_sum;
                        if (len_bad) begin
                            r_state <= ST_HUNT;
                        end else begin
                            r_len   <= s_axis_tdata[6:0];
                            r_wpos  <= 7'd0;
                            r_state <= ST_DATA;
                        end
                    end
                    ST_DATA: begin
                        r_sum  <= n_sum;
                        r_wpos <= n_wpos;
                        if (n_wpos >= r_len) begin
                            r_state <= ST_SUM;
                        end
                    end
                    ST_SUM: begin
                        r_state <= (r_sum == s_axis_tdata) ? ST_END : ST_HUNT;
                    end
                    ST_END: begin
                        if ((s_axis_tdata == r_end_marker) && addr_ok) begin
                            r_rd_cnt <= 7'd0;
                            r_state  <= ST_EMIT;
                        end else begin
                            r_state <= ST_HUNT;
                        end
                    end
                    default: r_state <= ST_HUNT;
                endcase
            end

            if (rd_issue) begin
                r_rd_cnt  <= n_rd_cnt;
                r_rd_last <= (n_rd_cnt == r_len);
                if (n_rd_cnt == r_len) begin
                    r_state <= ST_HUNT;
                end
            end
            r_rd_pend <= rd_issue;

            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= buf_rdata;
                r_out_last  <= r_rd_last;
                r_out_addr  <= r_addr;
                r_out_len   <= r_len;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_len, r_out_addr, r_out_byte};
    assign m_axis_tlast  = r_out_last;

    `ASSERT_IMPL(a_pend_out_free, r_rd_pend, !r_out_valid, "read lands on full output")
    `ASSERT_IMPL(a_rd_in_range, rd_issue, (r_rd_cnt < r_len), "buffer read beyond frame length")
    `ASSERT_NEXT(a_rd_pend_follows, rd_issue, r_rd_pend, "issued buffer read not tracked")
    `ASSERT_IMPL(a_out_len_nonzero, r_out_valid, (r_out_len != 7'd0), "zero length on output")

endmodule

`default_nettype wire

/* test/framed_packet_receiver_tb.sv */
`default_nettype none

module framed_packet_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit  = 2000000;
    localparam int DrainCycles = 12;
    localparam int RxItems     = 270;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_ADDR,
        RX_LEN,
        RX_DATA,
        RX_SUM,
        RX_END
    } t_rx_phase;

    typedef enum logic [1:0] {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_END
    } t_frame_fault;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] frame_address;
        logic [6:0] frame_length;
        logic       last;
    } t_payload_beat;

    class deframer_scoreboard;
        logic [7:0]    start_marker;
        logic [7:0]    end_marker;
        logic [7:0]    accept_address;
        logic [6:0]    length_limit;
        t_rx_phase     phase;
        logic [6:0]    write_pos;
        logic [6:0]    frame_len;
        logic [7:0]    running_sum;
        logic [7:0]    held_address;
        logic [7:0]    payload_buf[fpr_pkg::MaxPayload];
        t_payload_beat pending_beats[$];
        int            mismatches;

        function new();
            start_marker   = fpr_pkg::StartMarkerRst;
            end_marker     = fpr_pkg::EndMarkerRst;
            accept_address = fpr_pkg::AcceptAddrRst;
            length_limit   = fpr_pkg::LengthLimitRst;
            phase          = RX_HUNT;
            write_pos      = '0;
            frame_len      = '0;
            running_sum    = '0;
            held_address   = '0;
            mismatches     = 0;
        endfunction

        function void set_register(fpr_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                fpr_pkg::REG_START_MARKER:   start_marker   = value[7:0];
                fpr_pkg::REG_END_MARKER:     end_marker     = value[7:0];
                fpr_pkg::REG_ACCEPT_ADDRESS: accept_address = value[7:0];
                fpr_pkg::REG_LENGTH_LIMIT:   length_limit   = value[6:0];
                default: ;
            endcase
        endfunction

        function int effective_limit();
            return (length_limit > fpr_pkg::MaxPayload) ? fpr_pkg::MaxPayload
                                                        : int'(length_limit);
        endfunction

        function void accept_rx_byte(logic [7:0] b);
            t_payload_beat beat;
            case (phase)
                RX_HUNT: begin
                    if (b == start_marker) begin
                        write_pos   = '0;
                        running_sum = '0;
                        phase       = RX_ADDR;
                    end
                end
                RX_ADDR: begin
                    running_sum  = running_sum + b;
                    held_address = b;
                    phase        = (b == fpr_pkg::AnyAddress) ? RX_HUNT : RX_LEN;
                end
                RX_LEN: begin
                    running_sum = running_sum + b;
                    if (b == 8'd0 || int'(b) > effective_limit()) begin
                        phase = RX_HUNT;
                    end else begin
                        frame_len = b[6:0];
                        write_pos = '0;
                        phase     = RX_DATA;
                    end
                end
                RX_DATA: begin
                    running_sum = running_sum + b;
                    payload_buf[write_pos[5:0]] = b;
                    write_pos = write_pos + 7'd1;
                    if (write_pos >= frame_len) begin
                        phase = RX_SUM;
                    end
                end
                RX_SUM: begin
                    phase = (running_sum == b) ? RX_END : RX_HUNT;
                end
                RX_END: begin
                    phase = RX_HUNT;
                    if (b == end_marker &&
                        (accept_address == fpr_pkg::AnyAddress ||
                         accept_address == held_address)) begin
                        for (int i = 0; i < int'(frame_len); i++) begin
                            beat.payload_byte  = payload_buf[i];
                            beat.frame_address = held_address;
                            beat.frame_length  = frame_len;
                            beat.last          = (i == int'(frame_len) - 1);
                            pending_beats.push_back(beat);
                        end
                    end
                end
                default: phase = RX_HUNT;
            endcase
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function void check_payload_beat(logic [23:0] data, logic last);
            t_payload_beat want;
            string         msg;
            if (pending_beats.size() == 0) begin
                note_mismatch($sformatf("unexpected payload transaction: data %h last %b",
                                        data, last));
                return;
            end
            want = pending_beats.pop_front();
            if (data[7:0] !== want.payload_byte || data[15:8] !== want.frame_address ||
                data[22:16] !== want.frame_length || data[23] !== 1'b0 ||
                last !== want.last) begin
                msg = {$sformatf("payload mismatch: expected byte %h addr %h len %0d last %b",
                                 want.payload_byte, want.frame_address, want.frame_length,
                                 want.last),
                       $sformatf(", got byte %h addr %h len %0d pad %b last %b",
                                 data[7:0], data[15:8], data[22:16], data[23], last)};
                note_mismatch(msg);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] payload_byte, [15:8] frame_address,
                                       // [22:16] frame_length, [23] zero
    logic        m_axis_tlast;

    deframer_scoreboard sb = new();
    int rx_count = 0;
    int cycle_count = 0;

    framed_packet_receiver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_payload_beat(m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // stall the payload stream
    initial begin
        int gap;
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            gap = idle_cycles();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic send_rx_byte(input logic [7:0] b, input bit steady);
        int gap;
        gap = steady ? 0 : idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.accept_rx_byte(b);
        rx_count++;
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        foreach (seq[i]) send_rx_byte(seq[i], steady);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_register(input fpr_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] start_marker, input logic [7:0] end_marker,
                             input logic [7:0] accept_address, input logic [6:0] limit);
        wait_drained();
        write_register(fpr_pkg::REG_START_MARKER, 32'(start_marker));
        write_register(fpr_pkg::REG_END_MARKER, 32'(end_marker));
        write_register(fpr_pkg::REG_ACCEPT_ADDRESS, 32'(accept_address));
        write_register(fpr_pkg::REG_LENGTH_LIMIT, 32'(limit));
    endtask

    // hold_end leaves the end byte off so the frame can be closed later
    task automatic send_frame(input logic [7:0] addr, input int len,
                              input t_frame_fault fault, input bit hold_end);
        logic [7:0] seq[$];
        logic [7:0] sum;
        logic [7:0] b;
        seq.push_back(sb.start_marker);
        seq.push_back(addr);
        if (addr != fpr_pkg::AnyAddress) begin
            seq.push_back(8'(len));
            sum = addr + 8'(len);
            if (len != 0 && len <= sb.effective_limit()) begin
                for (int i = 0; i < len; i++) begin
                    b = 8'($urandom_range(0, 255));
                    seq.push_back(b);
                    sum = sum + b;
                end
                if (fault == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
                seq.push_back(sum);
                if (!hold_end) begin
                    if (fault == FRAME_BAD_END) begin
                        seq.push_back(sb.end_marker ^ 8'($urandom_range(1, 255)));
                    end else begin
                        seq.push_back(sb.end_marker);
                    end
                end
            end
        end
        send_bytes(seq);
    endtask

    task automatic send_random_frame();
        int r;
        int eff;
        int len;
        logic [7:0] addr;
        t_frame_fault fault;
        logic [7:0] noise[$];
        r     = $urandom_range(0, 99);
        eff   = sb.effective_limit();
        fault = FRAME_GOOD;
        if (sb.accept_address != fpr_pkg::AnyAddress && $urandom_range(0, 3) != 0) begin
            addr = sb.accept_address;
        end else begin
            addr = 8'($urandom_range(0, 254));
        end
        if ($urandom_range(0, 9) != 0) begin
            len = $urandom_range(1, (eff < 6) ? eff : 6);
        end else begin
            len = $urandom_range(1, eff);
        end
        if (r < 8) begin
            fault = FRAME_BAD_SUM;
        end else if (r < 15) begin
            fault = FRAME_BAD_END;
        end else if (r < 20) begin
            addr = fpr_pkg::AnyAddress;
        end else if (r < 25) begin
            len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(eff + 1, 255);
        end
        if (r >= 25 && r < 30) begin
            repeat ($urandom_range(1, 6)) noise.push_back(8'($urandom_range(0, 255)));
            send_bytes(noise);
        end else begin
            send_frame(addr, len, fault, 1'b0);
        end
    endtask

    task automatic run_phase(input int budget);
        int stop;
        stop = rx_count + budget;
        while (rx_count < stop) send_random_frame();
    endtask

    initial begin
        logic [7:0] seq[$];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // good frame, bad checksum equal to the start marker, wrong end byte equal to
        // the start marker, reserved address, zero length, length over the limit
        seq = {8'hAA, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h4D,
               8'hAA, 8'h56, 8'h01, 8'h80, 8'hAA,
               8'hAA, 8'hFE, 8'h01, 8'h7F, 8'h7E, 8'hAA,
               8'hAA, 8'hFF,
               8'hAA, 8'h12, 8'h00,
               8'hAA, 8'h34, 8'h41};
        send_bytes(seq);

        configure(8'h00, 8'hFF, fpr_pkg::AnyAddress, 7'd64);
        send_frame(8'($urandom_range(0, 254)), 64, FRAME_GOOD, 1'b0);
        run_phase(40);

        configure(8'hFF, 8'h00, 8'h00, 7'd1);
        run_phase(40);

        // change the end marker while a frame waits for its end byte
        send_frame(8'h00, 1, FRAME_GOOD, 1'b1);
        wait_drained();
        write_register(fpr_pkg::REG_END_MARKER, 32'h5A);
        seq = {sb.end_marker};
        send_bytes(seq);

        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hFE,
                  7'($urandom_range(2, 63)));
        run_phase(40);

        while (rx_count < RxItems) begin
            configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 1) == 0) ? fpr_pkg::AnyAddress
                                                  : 8'($urandom_range(0, 255)),
                      7'($urandom_range(1, 64)));
            run_phase(40);
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
